// ----- design/tfdc_pkg.sv -----
package tfdc_pkg;

  // Frame geometry.
  localparam int unsigned FrameWords  = 512;
  localparam int unsigned PosWidth    = $clog2(FrameWords);
  localparam int unsigned SlotWords   = 16;
  localparam int unsigned WindowWords = 64;
  localparam int unsigned CheckFirst  = 48;

  // Expected parameter in slot zero of a good frame.
  localparam logic [15:0] LabelValue = 16'h9999;

  // Request kinds.
  localparam logic KindData  = 1'b0;
  localparam logic KindClear = 1'b1;

  // One request: a frame word or a counter clear.
  typedef struct packed {
    logic        kind;
    logic [15:0] word;
    logic        frame_start;
  } req_t;

  // One result.
  typedef struct packed {
    logic signed [13:0] sample;
    logic               param_valid;
    logic [4:0]         param_slot;
    logic [15:0]        param_value;
    logic               window_done;
    logic [2:0]         window_index;
    logic               window_ok;
    logic               frame_done;
    logic               frame_good;
    logic [31:0]        good_frames;
    logic [31:0]        bad_frames;
  } rsp_t;

endpackage

// ----- design/tfdc_core.sv -----
module tfdc_core import tfdc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_fire_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  logic [PosWidth-1:0] pos_q, pos_d, pos_b;
  logic [15:0]         param_q, param_d, param_b, param_n;
  logic [15:0]         check_q, check_d, check_b, check_n;
  logic [14:0]         xor_q, xor_d, xor_b, xor_n;
  logic                awo_q, awo_d, awo_b, awo_n;
  logic                label_q, label_d, label_b, label_n;
  logic [31:0]         good_q, good_d, bad_q, bad_d;

  logic [15:0] pos_ext;
  logic [5:0]  win_pos;
  logic        slot_end, win_end, win_ok, frame_end, good;

  // Per-word decode, state update and result.
  always_comb begin
    // A frame start drops any partial frame before this word is taken.
    pos_b   = req_i.frame_start ? '0 : pos_q;
    param_b = req_i.frame_start ? '0 : param_q;
    check_b = req_i.frame_start ? '0 : check_q;
    xor_b   = req_i.frame_start ? '0 : xor_q;
    awo_b   = req_i.frame_start ? 1'b1 : awo_q;
    label_b = req_i.frame_start ? 1'b0 : label_q;

    pos_ext  = 16'(pos_b);
    win_pos  = pos_ext[5:0];
    slot_end = (pos_ext[3:0] == 4'(SlotWords - 1));
    win_end  = (win_pos == 6'(WindowWords - 1));
    frame_end = (pos_b == PosWidth'(FrameWords - 1));

    // Parameter stream.
    param_n = {param_b[14:0], req_i.word[14]};
    label_n = (slot_end && (pos_ext[15:4] == 12'd0)) ? (param_n == LabelValue) : label_b;

    // Check stream and computed check.
    check_n = (win_pos >= 6'(CheckFirst)) ? {check_b[14:0], req_i.word[15]} : check_b;
    xor_n   = xor_b ^ req_i.word[14:0];
    win_ok  = (check_n == {1'b0, xor_n});
    awo_n   = (win_end && !win_ok) ? 1'b0 : awo_b;
    good    = awo_n && label_n;

    // Next state.
    pos_d   = pos_q;
    param_d = param_q;
    check_d = check_q;
    xor_d   = xor_q;
    awo_d   = awo_q;
    label_d = label_q;
    good_d  = good_q;
    bad_d   = bad_q;
    rsp_o   = '0;

    if (req_i.kind == KindClear) begin
      good_d = '0;
      bad_d  = '0;
    end else begin
      rsp_o.sample = signed'(req_i.word[13:0]);
      if (slot_end) begin
        rsp_o.param_valid = 1'b1;
        rsp_o.param_slot  = pos_ext[8:4];
        rsp_o.param_value = param_n;
      end
      if (win_end) begin
        rsp_o.window_done  = 1'b1;
        rsp_o.window_index = pos_ext[8:6];
        rsp_o.window_ok    = win_ok;
      end
      if (frame_end) begin
        rsp_o.frame_done = 1'b1;
        rsp_o.frame_good = good;
        if (good) begin
          good_d = good_q + 32'd1;
        end else begin
          bad_d = bad_q + 32'd1;
        end
        pos_d   = '0;
        param_d = '0;
        check_d = '0;
        xor_d   = '0;
        awo_d   = 1'b1;
        label_d = 1'b0;
      end else begin
        pos_d   = pos_b + PosWidth'(1);
        param_d = param_n;
        check_d = win_end ? '0 : check_n;
        xor_d   = win_end ? '0 : xor_n;
        awo_d   = awo_n;
        label_d = label_n;
      end
    end
    rsp_o.good_frames = good_d;
    rsp_o.bad_frames  = bad_d;
  end

  // Frame state and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      param_q <= '0;
      check_q <= '0;
      xor_q   <= '0;
      awo_q   <= 1'b1;
      label_q <= 1'b0;
      good_q  <= '0;
      bad_q   <= '0;
    end else if (req_fire_i) begin
      pos_q   <= pos_d;
      param_q <= param_d;
      check_q <= check_d;
      xor_q   <= xor_d;
      awo_q   <= awo_d;
      label_q <= label_d;
      good_q  <= good_d;
      bad_q   <= bad_d;
    end
  end

endmodule

// ----- design/tfdc_outbuf.sv -----
module tfdc_outbuf import tfdc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_fire_i,
  input  rsp_t rsp_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  logic out_valid_q, skid_valid_q;
  rsp_t out_q, skid_q;
  logic out_fire;

  assign out_fire    = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Valid flags of the result register and the skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire_i) begin
      out_valid_q <= 1'b1;
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payloads.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire_i) begin
      if (!out_valid_q || out_fire) begin
        out_q <= rsp_i;
      end else begin
        skid_q <= rsp_i;
      end
    end
  end

endmodule

// ----- design/tool_frame_deframer_checker.sv -----
// Channel   Direction  Handshake                      Payload
// request   in         in_valid_i / in_stall_o        in_req_i  (req_t)
// result    out        out_valid_o / out_stall_i      out_rsp_o (rsp_t)
//
// Each request is decoded and the frame state updated in the cycle it is accepted;
// its result is registered in the output register, or in the skid stage if the output stalls.
// One request per cycle is sustained while the output is not stalled; a two-entry result buffer sets the slack.
// in_stall_o rises only once both result entries are held by a stalled output.
// Reset clears frame position, streams and both frame counters.
module tool_frame_deframer_checker import tfdc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  logic in_fire;
  logic full;
  rsp_t rsp;

  assign in_stall_o = full;
  assign in_fire    = in_valid_i && !full;

  // Deframing, checks and counters.
  tfdc_core u_core (
    .clk_i,
    .rst_ni,
    .req_fire_i (in_fire),
    .req_i      (in_req_i),
    .rsp_o      (rsp)
  );

  // Result register with skid stage.
  tfdc_outbuf u_outbuf (
    .clk_i,
    .rst_ni,
    .in_fire_i   (in_fire),
    .rsp_i       (rsp),
    .full_o      (full),
    .out_valid_o,
    .out_stall_i,
    .out_rsp_o
  );

endmodule
